// ===== sv/uart_dollar_line_framer_queue_defines.svh =====
// Assertion macros used by the back end of the serial line framer RTL.
`ifndef UART_DOLLAR_LINE_FRAMER_QUEUE_DEFINES_SVH
`define UART_DOLLAR_LINE_FRAMER_QUEUE_DEFINES_SVH

// Same-cycle implication, checked while the block is out of reset.
`define ULFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ulfq: same-cycle check failed");

// Next-cycle implication, checked while the block is out of reset.
`define ULFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ulfq: next-cycle check failed");

`endif

// ===== sv/ulfq_pkg.sv =====
// Shared constants, types and helpers for the serial line framer with a line queue.
package ulfq_pkg;

    // Sizing of the frame, the line slots and the queue.
    localparam int FRAME_MAX   = 32;
    localparam int LINE_SLOT   = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_RES     = 31;

    // One spare physical slot holds the frame under construction.
    localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int FLEN_W     = $clog2(FRAME_MAX);
    localparam int LLEN_W     = $clog2(LINE_SLOT);
    localparam int RCNT_W     = $clog2(MAX_RES + 1);
    localparam int MEM_DEPTH  = SLOT_COUNT * LINE_SLOT;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    // Command queue between the front and the back end.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Event counters.
    localparam int CNT_W   = 32;
    localparam int NUM_CNT = 6;
    localparam int CNT_RX   = 0;
    localparam int CNT_DROP = 1;
    localparam int CNT_OVR  = 2;
    localparam int CNT_FRM  = 3;
    localparam int CNT_NOI  = 4;
    localparam int CNT_PAR  = 5;

    // Stream widths.
    localparam int IN_FIELDS_W = 8 + 6;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 1 + 1 + 4;
    localparam int OUT_FIELDS_W = 8 + QCNT_W + NUM_CNT * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;

    // Opcodes of the request stream.
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Characters with a special meaning in the line protocol.
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    typedef enum logic {
        CK_RX,
        CK_READ
    } t_cmd_kind;

    // A classified request as it travels through the command queue.
    typedef struct packed {
        t_cmd_kind           kind;
        logic [7:0]          rx_data;
        logic                rx_valid;
        logic                err_ovr;
        logic                err_frm;
        logic                err_noi;
        logic                err_par;
        logic                is_dollar;
        logic                is_newline;
        logic                is_printable;
        logic                rd_none;
        logic [RCNT_W-1:0]   rd_cap;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FETCH,
        BS_EMIT
    } t_back_state;

    // Advance a physical slot index around the ring.
    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// ===== sv/ulfq_front.sv =====
// Front end: unpacks and classifies each incoming request for the command queue.
module ulfq_front (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ulfq_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [ulfq_pkg::IN_TUSER_W-1:0] i_s_tuser,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output ulfq_pkg::t_cmd                  o_q_cmd
);
    import ulfq_pkg::*;

    logic [7:0] rx_data;
    logic [5:0] buf_size;
    logic [5:0] buf_m1;

    assign rx_data  = i_s_tdata[7:0];
    assign buf_size = i_s_tdata[13:8];
    assign buf_m1   = buf_size - 6'd1;

    // A request is taken whenever the queue has room.
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

    // Classify the byte and work out how many characters a read may deliver.
    always_comb begin
        o_q_cmd.kind         = (i_s_tuser[0] == OP_READ) ? CK_READ : CK_RX;
        o_q_cmd.rx_data      = rx_data;
        o_q_cmd.rx_valid     = i_s_tuser[1];
        o_q_cmd.err_ovr      = i_s_tuser[2];
        o_q_cmd.err_frm      = i_s_tuser[3];
        o_q_cmd.err_noi      = i_s_tuser[4];
        o_q_cmd.err_par      = i_s_tuser[5];
        o_q_cmd.is_dollar    = (rx_data == CH_DOLLAR);
        o_q_cmd.is_newline   = (rx_data == CH_NEWLINE);
        o_q_cmd.is_printable = (rx_data >= CH_SPACE) && (rx_data <= CH_TILDE);
        o_q_cmd.rd_none      = (buf_size == 6'd0);
        o_q_cmd.rd_cap       = (int'(buf_m1) > MAX_RES) ? RCNT_W'(MAX_RES)
                                                        : buf_m1[RCNT_W-1:0];
    end

endmodule

// ===== sv/ulfq_cmd_fifo.sv =====
// Short queue of classified requests between the front and the back end.
module ulfq_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ulfq_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output ulfq_pkg::t_cmd o_cmd,
    output logic           o_full
);
    import ulfq_pkg::*;

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CMDQ_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CMDQ_AW:0]     r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/ulfq_back.sv =====
// Back end: frame assembly, line ring, event counters and result register.
`include "uart_dollar_line_framer_queue_defines.svh"

module ulfq_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  ulfq_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ulfq_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [ulfq_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    output logic                             o_m_tlast
);
    import ulfq_pkg::*;

    t_back_state          r_state, n_state;
    logic [FLEN_W-1:0]    r_frame_len, n_frame_len;
    logic                 r_in_frame, n_in_frame;
    logic [SLOT_W-1:0]    r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0]    r_rd_slot, n_rd_slot;
    logic [SLOT_W-1:0]    r_walk_slot, n_walk_slot;
    logic [QCNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]     r_cnt [NUM_CNT];
    logic [CNT_W-1:0]     n_cnt [NUM_CNT];
    logic [RCNT_W-1:0]    r_walk_n, n_walk_n;
    logic [RCNT_W-1:0]    r_walk_idx, n_walk_idx;

    logic [LLEN_W-1:0]    r_line_len [SLOT_COUNT];
    logic [7:0]           r_line_mem [MEM_DEPTH];
    logic [7:0]           r_mem_q;

    logic                 r_out_valid;
    logic                 r_out_got;
    logic                 r_out_cv;
    logic [7:0]           r_out_char;
    logic                 r_out_last;
    logic [QCNT_W-1:0]    r_out_queued;
    logic [CNT_W-1:0]     r_out_cnt [NUM_CNT];

    logic                 out_free;
    logic                 exec_rx;
    logic                 exec_rd;
    logic                 rd_issue;
    logic                 emit_char;
    logic                 load_out;
    logic                 rd_have;
    logic                 rd_walk;
    logic                 walk_last;
    logic [LLEN_W-1:0]    head_len;
    logic [RCNT_W-1:0]    walk_len;
    logic                 rx_err;
    logic                 drop_inc;
    logic                 mem_we;
    logic [LLEN_W-1:0]    mem_widx;
    logic [7:0]           mem_wdata;
    logic                 len_we;
    logic [LLEN_W-1:0]    len_wdata;
    logic [SLOT_W:0]      slot_sum;
    logic [SLOT_W-1:0]    slot_chk;

    // Flat address of one character inside a line slot.
    function automatic logic [MEM_AW-1:0] char_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [LLEN_W-1:0] idx);
        return MEM_AW'(slot) * MEM_AW'(LINE_SLOT) + MEM_AW'(idx);
    endfunction

    assign out_free  = !r_out_valid || i_m_tready;
    assign rx_err    = i_cmd.err_ovr || i_cmd.err_frm || i_cmd.err_noi || i_cmd.err_par;
    assign rd_have   = !i_cmd.rd_none && (r_count != '0);
    assign head_len  = r_line_len[r_rd_slot];
    assign walk_len  = (RCNT_W'(head_len) > i_cmd.rd_cap) ? i_cmd.rd_cap
                                                          : RCNT_W'(head_len);
    assign walk_last = ({1'b0, r_walk_idx} + 1'b1) == {1'b0, r_walk_n};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (rd_walk) begin
                    n_state = BS_FETCH;
                end
            end
            BS_FETCH: begin
                n_state = BS_EMIT;
            end
            BS_EMIT: begin
                if (out_free) begin
                    n_state = walk_last ? BS_IDLE : BS_FETCH;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        exec_rx   = 1'b0;
        exec_rd   = 1'b0;
        rd_issue  = 1'b0;
        emit_char = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                exec_rx = i_cmd_valid && out_free && (i_cmd.kind == CK_RX);
                exec_rd = i_cmd_valid && out_free && (i_cmd.kind == CK_READ);
            end
            BS_FETCH: begin
                rd_issue = 1'b1;
            end
            BS_EMIT: begin
                emit_char = out_free;
            end
            default: begin
                exec_rx = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = exec_rx || exec_rd;
    assign rd_walk   = exec_rd && rd_have && (walk_len != '0);
    assign load_out  = exec_rx || (exec_rd && !rd_walk) || emit_char;

    // Frame assembly, ring bookkeeping and counter updates.
    always_comb begin
        n_frame_len = r_frame_len;
        n_in_frame  = r_in_frame;
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_count     = r_count;
        n_walk_slot = r_walk_slot;
        n_walk_n    = r_walk_n;
        n_walk_idx  = r_walk_idx;
        drop_inc    = 1'b0;
        mem_we      = 1'b0;
        mem_widx    = '0;
        mem_wdata   = CH_DOLLAR;
        len_we      = 1'b0;
        len_wdata   = '0;
        for (int i = 0; i < NUM_CNT; i++) begin
            n_cnt[i] = r_cnt[i];
        end

        if (exec_rx) begin
            if (i_cmd.rx_valid) n_cnt[CNT_RX] = r_cnt[CNT_RX] + 1'b1;
            if (i_cmd.err_ovr)  n_cnt[CNT_OVR] = r_cnt[CNT_OVR] + 1'b1;
            if (i_cmd.err_frm)  n_cnt[CNT_FRM] = r_cnt[CNT_FRM] + 1'b1;
            if (i_cmd.err_noi)  n_cnt[CNT_NOI] = r_cnt[CNT_NOI] + 1'b1;
            if (i_cmd.err_par)  n_cnt[CNT_PAR] = r_cnt[CNT_PAR] + 1'b1;
            if (rx_err) begin
                // Any receiver error discards the frame without counting a drop.
                n_in_frame  = 1'b0;
                n_frame_len = '0;
            end else if (i_cmd.rx_valid) begin
                if (i_cmd.is_dollar) begin
                    n_in_frame  = 1'b1;
                    n_frame_len = FLEN_W'(1);
                    mem_we      = 1'b1;
                    mem_widx    = '0;
                    mem_wdata   = CH_DOLLAR;
                end else if (r_in_frame) begin
                    if (i_cmd.is_newline) begin
                        // Commit the frame in place and advance the ring.
                        len_we      = 1'b1;
                        len_wdata   = (int'(r_frame_len) > LINE_SLOT - 1)
                                      ? LLEN_W'(LINE_SLOT - 1) : LLEN_W'(r_frame_len);
                        n_wr_slot   = slot_next(r_wr_slot);
                        n_frame_len = '0;
                        n_in_frame  = 1'b0;
                        if (r_count < QCNT_W'(QUEUE_DEPTH)) begin
                            n_count = r_count + 1'b1;
                        end else begin
                            n_rd_slot = slot_next(r_rd_slot);
                            drop_inc  = 1'b1;
                        end
                    end else if (!i_cmd.is_printable) begin
                        n_in_frame  = 1'b0;
                        n_frame_len = '0;
                        drop_inc    = 1'b1;
                    end else if (r_frame_len < FLEN_W'(FRAME_MAX - 1)) begin
                        mem_we      = (int'(r_frame_len) < LINE_SLOT);
                        mem_widx    = LLEN_W'(r_frame_len);
                        mem_wdata   = i_cmd.rx_data;
                        n_frame_len = r_frame_len + 1'b1;
                    end else begin
                        n_in_frame  = 1'b0;
                        n_frame_len = '0;
                        drop_inc    = 1'b1;
                    end
                end
            end
        end

        // A read pops the oldest line at once and then walks its characters.
        if (exec_rd && rd_have) begin
            n_rd_slot   = slot_next(r_rd_slot);
            n_count     = r_count - 1'b1;
            n_walk_slot = r_rd_slot;
            n_walk_n    = walk_len;
            n_walk_idx  = '0;
        end
        if (emit_char) begin
            n_walk_idx = r_walk_idx + 1'b1;
        end

        if (drop_inc) begin
            n_cnt[CNT_DROP] = r_cnt[CNT_DROP] + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_frame_len <= '0;
            r_in_frame  <= 1'b0;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_count     <= '0;
            r_walk_slot <= '0;
            r_walk_n    <= '0;
            r_walk_idx  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_frame_len <= n_frame_len;
            r_in_frame  <= n_in_frame;
            r_wr_slot   <= n_wr_slot;
            r_rd_slot   <= n_rd_slot;
            r_count     <= n_count;
            r_walk_slot <= n_walk_slot;
            r_walk_n    <= n_walk_n;
            r_walk_idx  <= n_walk_idx;
            r_out_valid <= load_out || (r_out_valid && !i_m_tready);
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // Line store and line lengths; the frame is built directly in its slot.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[char_addr(r_wr_slot, mem_widx)] <= mem_wdata;
        end
        if (rd_issue) begin
            r_mem_q <= r_line_mem[char_addr(r_walk_slot, LLEN_W'(r_walk_idx))];
        end
        if (len_we) begin
            r_line_len[r_wr_slot] <= len_wdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_got    <= emit_char || (exec_rd && rd_have);
            r_out_cv     <= emit_char;
            r_out_char   <= emit_char ? r_mem_q : 8'd0;
            r_out_last   <= !emit_char || walk_last;
            r_out_queued <= n_count;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_out_cnt[i] <= n_cnt[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_cv, r_out_got};
    assign o_m_tdata  = {OUT_PAD_W'(0),
                         r_out_cnt[CNT_PAR], r_out_cnt[CNT_NOI], r_out_cnt[CNT_FRM],
                         r_out_cnt[CNT_OVR], r_out_cnt[CNT_DROP], r_out_cnt[CNT_RX],
                         r_out_queued, r_out_char};

    // Expected write slot from the read slot and the number of queued lines.
    assign slot_sum = {1'b0, r_rd_slot} + (SLOT_W + 1)'(r_count);
    assign slot_chk = (int'(slot_sum) >= SLOT_COUNT) ? SLOT_W'(int'(slot_sum) - SLOT_COUNT)
                                                     : slot_sum[SLOT_W-1:0];

    `ULFQ_ASSERT_IMPL(a_ring_slots_agree, i_clk, i_rst_n, 1'b1, slot_chk == r_wr_slot)
    `ULFQ_ASSERT_IMPL(a_ring_not_over, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))
    `ULFQ_ASSERT_IMPL(a_idle_frame_empty, i_clk, i_rst_n, !r_in_frame, r_frame_len == '0)
    `ULFQ_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state != BS_IDLE, r_walk_idx < r_walk_n)
    `ULFQ_ASSERT_NEXT(a_pop_lowers_count, i_clk, i_rst_n, exec_rd && rd_have, r_count + 1'b1 == $past(r_count))

endmodule

// ===== sv/uart_dollar_line_framer_queue.sv =====
// A receive request passes the command queue, then its status result is registered.
// A read presents its characters one at a time, each through a fetch and an emit state
// (one line store read and one result register load per character).
// Throughput: one receive request per cycle while results flow and no read walk runs.
// Reset (synchronous, active low) empties the queue, the frame and the counters;
// line store contents are left as they are and need no clearing pass.
module uart_dollar_line_framer_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // rx_data[7:0], buffer_size[5:0], zero padding
    input  logic [ulfq_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // opcode, rx_valid, err_overrun, err_framing, err_noise, err_parity
    input  logic [ulfq_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // line_char[7:0], lines_queued[3:0], rx_bytes, dropped_frames, overrun_errors,
    // framing_errors, noise_errors, parity_errors (32 bits each), zero padding
    output logic [ulfq_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // got_line, char_valid
    output logic [ulfq_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    output logic                             o_m_tlast
);
    import ulfq_pkg::*;

    t_cmd q_in_cmd;
    t_cmd q_out_cmd;
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;

    // Request classification.
    ulfq_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    // Decoupling queue.
    ulfq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .o_full  (q_full)
    );

    // Execution and result delivery.
    ulfq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the serial line framer with its queue of complete lines.
module tb_top;

    import ulfq_pkg::*;

    // Bit positions of the result fields inside o_m_tdata and o_m_tuser.
    localparam int CHAR_LSB   = 0;
    localparam int QUEUED_LSB = 8;
    localparam int COUNT_LSB  = 8 + QCNT_W;
    localparam int GOT_BIT    = 0;
    localparam int CVALID_BIT = 1;

    // One request as the sender sees it.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       valid;
        logic [3:0] errs;   // parity, noise, framing, overrun from the top bit down
        logic [5:0] bs;
    } serial_req_t;

    // One result as the receiver should see it.
    typedef struct packed {
        logic                           got;
        logic                           cv;
        logic [7:0]                     ch;
        logic                           last;
        logic [QCNT_W-1:0]              queued;
        logic [NUM_CNT-1:0][CNT_W-1:0]  cnt;
    } line_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [IN_TUSER_W-1:0]  i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   o_m_tlast;

    uart_dollar_line_framer_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Stimulus and scoreboard bookkeeping.
    serial_req_t  pending_reqs[$];
    serial_req_t  cur_req;
    line_result_t expected_results[$];
    int           pushed_count   = 0;
    int           accepted_count = 0;
    int           mismatch_count = 0;
    bit           req_taken      = 1'b0;
    int           send_idle_pct  = 0;
    int           stall_pct      = 0;
    bit           rx_hold        = 1'b0;

    string cnt_label [NUM_CNT] = '{"rx_bytes", "dropped_frames", "overrun_errors",
                                   "framing_errors", "noise_errors", "parity_errors"};

    // Predictor state: the queued lines, the frame being built and the counters.
    logic [7:0]                    line_bytes [QUEUE_DEPTH][LINE_SLOT];
    int                            line_len   [QUEUE_DEPTH];
    logic [7:0]                    frame_bytes [FRAME_MAX];
    int                            frame_len  = 0;
    bit                            in_frame   = 1'b0;
    int                            wr_slot    = 0;
    int                            rd_slot    = 0;
    int                            line_count = 0;
    logic [NUM_CNT-1:0][CNT_W-1:0] counts     = '0;

    // Clock with a period of two time units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s at %0t: expected %0h, got %0h", field, $time, want, got);
        mismatch_count++;
    endtask

    task automatic add_result(input logic got, input logic cv, input logic [7:0] ch,
                              input logic last);
        line_result_t r;
        r.got    = got;
        r.cv     = cv;
        r.ch     = ch;
        r.last   = last;
        r.queued = QCNT_W'(line_count);
        r.cnt    = counts;
        expected_results.push_back(r);
    endtask

    // Works out the results of one accepted request and advances the predictor state.
    task automatic predict_line_results(input serial_req_t r);
        logic err;
        int   n;
        int   slot;
        err = |r.errs;
        if (r.op == OP_RX) begin
            if (r.valid || err) begin
                if (r.valid)   counts[CNT_RX]  = counts[CNT_RX] + 1;
                if (r.errs[0]) counts[CNT_OVR] = counts[CNT_OVR] + 1;
                if (r.errs[1]) counts[CNT_FRM] = counts[CNT_FRM] + 1;
                if (r.errs[2]) counts[CNT_NOI] = counts[CNT_NOI] + 1;
                if (r.errs[3]) counts[CNT_PAR] = counts[CNT_PAR] + 1;
                if (err) begin
                    // Any receiver error silently abandons the frame.
                    in_frame  = 1'b0;
                    frame_len = 0;
                end else if (r.data == CH_DOLLAR) begin
                    in_frame       = 1'b1;
                    frame_bytes[0] = r.data;
                    frame_len      = 1;
                end else if (in_frame) begin
                    if (r.data == CH_NEWLINE) begin
                        // Push the frame; a full ring loses its oldest line.
                        n = (frame_len > LINE_SLOT - 1) ? LINE_SLOT - 1 : frame_len;
                        for (int i = 0; i < n; i++) line_bytes[wr_slot][i] = frame_bytes[i];
                        line_len[wr_slot] = n;
                        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                        if (line_count < QUEUE_DEPTH) begin
                            line_count++;
                        end else begin
                            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                            counts[CNT_DROP] = counts[CNT_DROP] + 1;
                        end
                        frame_len = 0;
                        in_frame  = 1'b0;
                    end else if (r.data < CH_SPACE || r.data > CH_TILDE ||
                                 frame_len >= FRAME_MAX - 1) begin
                        in_frame  = 1'b0;
                        frame_len = 0;
                        counts[CNT_DROP] = counts[CNT_DROP] + 1;
                    end else begin
                        frame_bytes[frame_len] = r.data;
                        frame_len++;
                    end
                end
            end
            add_result(1'b0, 1'b0, 8'h00, 1'b1);
        end else if (r.bs == 0 || line_count == 0) begin
            add_result(1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
            // Deliver at most bs-1 characters of the oldest line and pop it.
            slot = rd_slot;
            n    = line_len[slot];
            if (n > int'(r.bs) - 1) n = int'(r.bs) - 1;
            if (n > MAX_RES) n = MAX_RES;
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            line_count--;
            if (n == 0) begin
                add_result(1'b1, 1'b0, 8'h00, 1'b1);
            end else begin
                for (int i = 0; i < n; i++)
                    add_result(1'b1, 1'b1, line_bytes[slot][i], i == n - 1);
            end
        end
    endtask

    task automatic push_req(input logic op, input logic [7:0] data, input logic valid,
                            input logic [3:0] errs, input logic [5:0] bs);
        serial_req_t r;
        r.op    = op;
        r.data  = data;
        r.valid = valid;
        r.errs  = errs;
        r.bs    = bs;
        pending_reqs.push_back(r);
        pushed_count++;
    endtask

    task automatic push_byte(input logic [7:0] data);
        push_req(OP_RX, data, 1'b1, 4'b0000, 6'($urandom_range(0, 32)));
    endtask

    // A read with junk in the fields that a read ignores.
    task automatic push_read(input int bs);
        push_req(OP_READ, 8'($urandom), 1'($urandom), 4'($urandom), 6'(bs));
    endtask

    // A '$' frame with random printable content, usually closed by a newline.
    task automatic add_line(input int payload, input bit broken);
        logic [7:0] c;
        push_byte(CH_DOLLAR);
        for (int i = 0; i < payload; i++) begin
            do c = 8'($urandom_range(CH_SPACE, CH_TILDE)); while (c == CH_DOLLAR);
            if ($urandom_range(0, 29) == 0)
                push_req(OP_RX, 8'($urandom), 1'b0, 4'b0000, 6'($urandom_range(0, 32)));
            push_byte(c);
        end
        if (!broken) begin
            push_byte(CH_NEWLINE);
        end else begin
            case ($urandom_range(0, 2))
                0: push_req(OP_RX, 8'($urandom), 1'($urandom), 4'b0001 << $urandom_range(0, 3),
                            6'($urandom_range(0, 32)));
                1: begin
                    c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                    : 8'($urandom_range(127, 255));
                    if (c == CH_NEWLINE) c = 8'h7F;
                    push_byte(c);
                end
                default: ;
            endcase
        end
    endtask

    task automatic add_random(input int target);
        int start;
        int r;
        start = pushed_count;
        while (pushed_count - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                r = $urandom_range(0, 99);
                add_line((r < 75) ? $urandom_range(0, 6) :
                         (r < 93) ? $urandom_range(7, 28) : $urandom_range(29, 31),
                         $urandom_range(0, 9) == 0);
            end else if (r < 80) begin
                r = $urandom_range(0, 99);
                push_read((r < 8)  ? 0 :
                          (r < 16) ? 1 :
                          (r < 30) ? $urandom_range(2, 8) :
                          (r < 65) ? 32 : $urandom_range(9, 32));
            end else begin
                push_req(OP_RX, 8'($urandom), 1'($urandom),
                         {$urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                          $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0},
                         6'($urandom_range(0, 32)));
            end
        end
    endtask

    // Sender pause: wait until every request is in and every result is out.
    task automatic drain;
        while (accepted_count != pushed_count || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: holds the current request until it is taken.
    always @(negedge i_clk) begin : feed
        if (i_rst_n && (!i_s_tvalid || req_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, cur_req.bs, cur_req.data};
                i_s_tuser  <= {cur_req.errs, cur_req.valid, cur_req.op};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        i_m_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    // Predict on each accepted request and check each accepted result.
    always @(posedge i_clk) begin : observe
        line_result_t want;
        req_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (req_taken) begin
            predict_line_results(cur_req);
            accepted_count++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", 32'h0, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (want.got != o_m_tuser[GOT_BIT])
                    report_mismatch("got_line", want.got, o_m_tuser[GOT_BIT]);
                if (want.cv != o_m_tuser[CVALID_BIT])
                    report_mismatch("char_valid", want.cv, o_m_tuser[CVALID_BIT]);
                if (want.ch != o_m_tdata[CHAR_LSB +: 8])
                    report_mismatch("line_char", want.ch, o_m_tdata[CHAR_LSB +: 8]);
                if (want.last != o_m_tlast)
                    report_mismatch("last", want.last, o_m_tlast);
                if (want.queued != o_m_tdata[QUEUED_LSB +: QCNT_W])
                    report_mismatch("lines_queued", want.queued,
                                    o_m_tdata[QUEUED_LSB +: QCNT_W]);
                for (int k = 0; k < NUM_CNT; k++) begin
                    if (want.cnt[k] != o_m_tdata[COUNT_LSB + CNT_W * k +: CNT_W])
                        report_mismatch(cnt_label[k], want.cnt[k],
                                        o_m_tdata[COUNT_LSB + CNT_W * k +: CNT_W]);
                end
            end
        end
    end

    // Reset, then the directed part and four random phases with different idling.
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Read of an empty ring, then an event with neither data nor error.
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd32);
        push_req(OP_RX, 8'hFF, 1'b0, 4'b0000, 6'd63);
        // Printable extremes in one line, then reads with buffer sizes zero and one.
        push_byte(CH_DOLLAR);
        push_byte("A");
        push_byte(CH_TILDE);
        push_byte(CH_SPACE);
        push_byte(CH_NEWLINE);
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd0);
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd1);
        // A read that gets only the leading dollar.
        push_byte(CH_DOLLAR);
        push_byte("x");
        push_byte(CH_NEWLINE);
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd2);
        // All four errors at once, then bytes that arrive outside a frame.
        push_byte(CH_DOLLAR);
        push_req(OP_RX, "b", 1'b1, 4'b1111, 6'd32);
        push_byte("b");
        push_byte(CH_NEWLINE);
        // A non-printable byte drops the frame; a second dollar restarts it.
        push_byte(CH_DOLLAR);
        push_byte(8'h7F);
        push_byte(CH_DOLLAR);
        push_byte(CH_DOLLAR);
        push_byte("z");
        push_byte(CH_NEWLINE);
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd32);
        push_req(OP_READ, 8'h00, 1'b0, 4'b0000, 6'd32);
        drain();

        // No idling: ring overflow, longest line, over-long frame, then random traffic.
        for (int i = 0; i < 10; i++) add_line($urandom_range(0, 3), 1'b0);
        add_line(30, 1'b0);
        push_read(32);
        add_line(31, 1'b0);
        add_random(20);
        drain();

        // Sender mostly idle.
        send_idle_pct = 86;
        add_random(65);
        drain();

        // Receiver mostly stalled, opening with a long hold so the input backs up.
        send_idle_pct = 0;
        stall_pct     = 86;
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        add_random(65);
        drain();

        // Light idling on both sides.
        send_idle_pct = 10;
        stall_pct     = 10;
        add_random(65);
        drain();

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
